// ----- hdl/abr_pkg.sv -----
// ----------------------------------------------------------------------------
// abr_pkg
// Shared constants and types of the alpha blend shape rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package abr_pkg;

  // framebuffer geometry
  localparam int unsigned FB_SIDE  = 256;
  localparam int unsigned FB_W     = $clog2(FB_SIDE);
  localparam int unsigned FB_DEPTH = FB_SIDE * FB_SIDE;
  localparam int unsigned ADDR_W   = $clog2(FB_DEPTH);

  // request field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned RAD_W   = 10;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 4 * CH_W;

  // bounding box arithmetic, wide enough for center +- radius + 1
  localparam int unsigned CW = 14;

  // shared multiply-add unit
  localparam int unsigned OP_W  = 12;
  localparam int unsigned ACC_W = 2 * OP_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_FILL  = 3'd1,
    FUNC_RING  = 3'd2,
    FUNC_PLOT  = 3'd3,
    FUNC_READ  = 3'd4
  } func_e;

  typedef struct packed {
    logic                    en;
    logic signed [OP_W-1:0]  op_a;
    logic signed [OP_W-1:0]  op_b;
    logic signed [ACC_W-1:0] addend;
  } mac_req_t;

endpackage

`default_nettype wire

// ----- hdl/alpha_blend_shape_rasterizer.sv -----
// ----------------------------------------------------------------------------
// alpha_blend_shape_rasterizer
// 2D draw engine over a square RGBA framebuffer with alpha blending.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request is finished, and done_o pulses for one cycle with the
// result, which must be captured in that cycle. Timing is set by the one
// shared multiply-add unit and the single framebuffer: a fill or ring sets up
// its clipped bounding box and squared radius, then takes each box pixel
// through delta, square and test steps, a drawn pixel also through a blend of
// its four channels and a write-back; a plot runs these steps for its one
// pixel and a read stops at the test, either ending at setup when its pixel
// is off the buffer. An undefined command ends at decode; a clear zeroes the
// framebuffer. After reset a sweep zeroes it with busy high and no done_o pulse.
`default_nettype none

module alpha_blend_shape_rasterizer import abr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [COORD_W-1:0] x_a_i,
  input  logic signed [COORD_W-1:0] y_a_i,
  input  logic signed [COORD_W-1:0] x_b_i,
  input  logic signed [COORD_W-1:0] y_b_i,
  input  logic [RAD_W-1:0]          radius_i,
  input  logic [CH_W-1:0]           red_i,
  input  logic [CH_W-1:0]           green_i,
  input  logic [CH_W-1:0]           blue_i,
  input  logic [CH_W-1:0]           alpha_i,
  output logic                      done_o,
  output logic [PIX_W-1:0]          pixel_rgba_o,
  output logic                      in_bounds_o
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_BOX,
    S_RAD,
    S_LIM,
    S_DELTA,
    S_SQX,
    S_SQY,
    S_TEST,
    S_BLEND,
    S_WB
  } state_e;

  localparam logic signed [CW-1:0] FB_MAX  = CW'(FB_SIDE - 1);
  localparam logic signed [CW-1:0] ONE_C   = CW'(1);
  localparam logic [ADDR_W-1:0]    LAST_AD = ADDR_W'(FB_DEPTH - 1);

  function automatic logic signed [CW-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {{(CW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] zx(input logic [RAD_W-1:0] v);
    return $signed({{(CW-RAD_W){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] lo_clip(input logic signed [CW-1:0] v);
    return (v < 0) ? '0 : v;
  endfunction

  function automatic logic signed [CW-1:0] hi_clip(input logic signed [CW-1:0] v);
    return (v > FB_MAX) ? FB_MAX : v;
  endfunction

  // exact v / 255 for v below 65280
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] v);
    logic [2*CH_W:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[2*CH_W-1:CH_W]};
    return t[2*CH_W-1:CH_W];
  endfunction

  // control state
  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  logic              clr_cmd_q;
  logic [1:0]        ch_q;
  logic              done_q;
  logic [PIX_W-1:0]  pix_q;
  logic              inb_q;

  // request and scan datapath
  logic [FUNC_W-1:0]         func_q;
  logic signed [COORD_W-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [RAD_W-1:0]          rad_q;
  logic [CH_W-1:0]           red_q, green_q, blue_q, alpha_q;
  logic signed [CW-1:0]      bx0_q, bx1_q, by0_q, by1_q;
  logic signed [CW-1:0]      xl_q, xr_q, yt_q, ybt_q;
  logic [FB_W-1:0]           xs_q, xe_q, ye_q, x_q, y_q;
  logic                      empty_q;
  logic signed [ACC_W-1:0]   rr_q, lo_q, hi_q;
  logic signed [OP_W-1:0]    dx_q, dy_q;
  logic [CH_W-1:0]           res_r_q, res_g_q, res_b_q;

  // combinational
  mac_req_t                mac_req;
  logic signed [ACC_W-1:0] acc;
  logic signed [CW-1:0]    cx0, cx1, cy0, cy1;
  logic signed [CW-1:0]    x_c, y_c, dx_w, dy_w;
  logic signed [ACC_W-1:0] two_rad;
  logic                    hit, last_px, step;
  logic [FB_W-1:0]         nx, ny;
  logic [ADDR_W-1:0]       pix_addr;
  logic [CH_W-1:0]         src_ch, dst_ch, a_div;
  logic [CH_W:0]           a_sum;
  logic [CH_W-1:0]         a_new;
  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [PIX_W-1:0]        ram_wdata, ram_rdata;

  assign busy = (state_q != S_IDLE);

  assign cx0 = lo_clip(bx0_q);
  assign cx1 = hi_clip(bx1_q);
  assign cy0 = lo_clip(by0_q);
  assign cy1 = hi_clip(by1_q);

  assign x_c     = $signed({{(CW-FB_W){1'b0}}, x_q});
  assign y_c     = $signed({{(CW-FB_W){1'b0}}, y_q});
  assign two_rad = $signed({{(ACC_W-RAD_W-1){1'b0}}, rad_q, 1'b0});

  // distance past the inset edges (fill) or from the center (ring)
  always_comb begin
    dx_w = '0;
    dy_w = '0;
    if (func_q == FUNC_RING) begin
      dx_w = x_c - sx(xa_q);
      dy_w = y_c - sx(ya_q);
    end else if (func_q == FUNC_FILL) begin
      if (x_c < xl_q) begin
        dx_w = xl_q - x_c;
      end else if (x_c > xr_q) begin
        dx_w = x_c - xr_q;
      end
      if (y_c < yt_q) begin
        dy_w = yt_q - y_c;
      end else if (y_c > ybt_q) begin
        dy_w = y_c - ybt_q;
      end
    end
  end

  always_comb begin
    priority if (func_q == FUNC_FILL) begin
      hit = !((dx_q != '0) && (dy_q != '0) && (acc > rr_q));
    end else if (func_q == FUNC_RING) begin
      hit = (acc >= lo_q) && (acc <= hi_q);
    end else begin
      hit = (func_q == FUNC_PLOT);
    end
  end

  assign last_px  = (x_q == xe_q) && (y_q == ye_q);
  assign nx       = (x_q == xe_q) ? xs_q : x_q + FB_W'(1);
  assign ny       = (x_q == xe_q) ? y_q + FB_W'(1) : y_q;
  assign step     = ((state_q == S_TEST) && !hit) || (state_q == S_WB);
  assign pix_addr = ADDR_W'(y_q) * ADDR_W'(FB_SIDE) + ADDR_W'(x_q);

  // channel under blend; alpha uses a zero source so the product is dst * (255 - a)
  always_comb begin
    dst_ch = ram_rdata[{ch_q, 3'b000} +: CH_W];
    unique case (ch_q)
      2'd0:    src_ch = red_q;
      2'd1:    src_ch = green_q;
      2'd2:    src_ch = blue_q;
      default: src_ch = '0;
    endcase
  end

  always_comb begin
    mac_req = '0;
    unique case (state_q)
      S_RAD: begin
        mac_req.en   = 1'b1;
        mac_req.op_a = $signed({{(OP_W-RAD_W){1'b0}}, rad_q});
        mac_req.op_b = $signed({{(OP_W-RAD_W){1'b0}}, rad_q});
      end
      S_SQX: begin
        mac_req.en   = 1'b1;
        mac_req.op_a = dx_q;
        mac_req.op_b = dx_q;
      end
      S_SQY: begin
        mac_req.en     = 1'b1;
        mac_req.op_a   = dy_q;
        mac_req.op_b   = dy_q;
        mac_req.addend = acc;
      end
      S_BLEND: begin
        mac_req.en     = 1'b1;
        mac_req.op_a   = $signed({{(OP_W-CH_W){1'b0}}, src_ch})
                       - $signed({{(OP_W-CH_W){1'b0}}, dst_ch});
        mac_req.op_b   = $signed({{(OP_W-CH_W){1'b0}}, alpha_q});
        mac_req.addend = $signed(ACC_W'({dst_ch, 8'h00}) - ACC_W'(dst_ch));
      end
      default: mac_req = '0;
    endcase
  end

  assign a_div = div255(acc[2*CH_W-1:0]);
  assign a_sum = {1'b0, alpha_q} + {1'b0, a_div};
  assign a_new = a_sum[CH_W] ? {CH_W{1'b1}} : a_sum[CH_W-1:0];

  assign ram_we    = (state_q == S_CLR) || (state_q == S_WB);
  assign ram_waddr = (state_q == S_CLR) ? clr_q : pix_addr;
  assign ram_wdata = (state_q == S_CLR) ? '0 : {a_new, res_b_q, res_g_q, res_r_q};
  assign ram_re    = (state_q == S_DELTA);

  abr_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  abr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FB_DEPTH)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      clr_cmd_q <= 1'b0;
      ch_q      <= '0;
      done_q    <= 1'b0;
      pix_q     <= '0;
      inb_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pix_q  <= '0;
      inb_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_BOX;
          end
        end
        S_BOX: begin
          priority if (func_q == FUNC_CLEAR) begin
            state_q   <= S_CLR;
            clr_q     <= '0;
            clr_cmd_q <= 1'b1;
          end else if (func_q == FUNC_FILL || func_q == FUNC_RING ||
                       func_q == FUNC_PLOT || func_q == FUNC_READ) begin
            state_q <= S_RAD;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == LAST_AD) begin
            // the sweep after reset finishes silently
            done_q    <= clr_cmd_q;
            clr_cmd_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        S_RAD: state_q <= S_LIM;
        S_LIM: begin
          if (empty_q) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DELTA;
          end
        end
        S_DELTA: state_q <= S_SQX;
        S_SQX:   state_q <= S_SQY;
        S_SQY:   state_q <= S_TEST;
        S_TEST: begin
          priority if (func_q == FUNC_READ) begin
            done_q  <= 1'b1;
            pix_q   <= ram_rdata;
            inb_q   <= 1'b1;
            state_q <= S_IDLE;
          end else if (hit) begin
            ch_q    <= '0;
            state_q <= S_BLEND;
          end else if (last_px) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DELTA;
          end
        end
        S_BLEND: begin
          if (ch_q == 2'd3) begin
            state_q <= S_WB;
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        S_WB: begin
          priority if (func_q == FUNC_PLOT) begin
            done_q  <= 1'b1;
            inb_q   <= 1'b1;
            state_q <= S_IDLE;
          end else if (last_px) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DELTA;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      func_q  <= func_i;
      xa_q    <= x_a_i;
      ya_q    <= y_a_i;
      xb_q    <= x_b_i;
      yb_q    <= y_b_i;
      rad_q   <= radius_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= alpha_i;
    end
    if (state_q == S_BOX) begin
      xl_q  <= sx(xa_q) + zx(rad_q);
      xr_q  <= sx(xb_q) - zx(rad_q);
      yt_q  <= sx(ya_q) + zx(rad_q);
      ybt_q <= sx(yb_q) - zx(rad_q);
      priority if (func_q == FUNC_FILL) begin
        bx0_q <= sx(xa_q);
        bx1_q <= sx(xb_q);
        by0_q <= sx(ya_q);
        by1_q <= sx(yb_q);
      end else if (func_q == FUNC_RING) begin
        bx0_q <= sx(xa_q) - zx(rad_q) - ONE_C;
        bx1_q <= sx(xa_q) + zx(rad_q) + ONE_C;
        by0_q <= sx(ya_q) - zx(rad_q) - ONE_C;
        by1_q <= sx(ya_q) + zx(rad_q) + ONE_C;
      end else begin
        // single pixel box for plot and read
        bx0_q <= sx(xa_q);
        bx1_q <= sx(xa_q);
        by0_q <= sx(ya_q);
        by1_q <= sx(ya_q);
      end
    end
    if (state_q == S_RAD) begin
      xs_q    <= cx0[FB_W-1:0];
      xe_q    <= cx1[FB_W-1:0];
      ye_q    <= cy1[FB_W-1:0];
      x_q     <= cx0[FB_W-1:0];
      y_q     <= cy0[FB_W-1:0];
      empty_q <= (cx0 > cx1) || (cy0 > cy1);
    end
    if (state_q == S_LIM) begin
      rr_q <= acc;
      lo_q <= acc - two_rad;
      hi_q <= acc + two_rad;
    end
    if (state_q == S_DELTA) begin
      dx_q <= dx_w[OP_W-1:0];
      dy_q <= dy_w[OP_W-1:0];
    end
    if (state_q == S_BLEND) begin
      // product of the previous channel is in the accumulator now
      unique case (ch_q)
        2'd1:    res_r_q <= div255(acc[2*CH_W-1:0]);
        2'd2:    res_g_q <= div255(acc[2*CH_W-1:0]);
        2'd3:    res_b_q <= div255(acc[2*CH_W-1:0]);
        default: ;
      endcase
    end
    if (step) begin
      x_q <= nx;
      y_q <= ny;
    end
  end

  assign done_o       = done_q;
  assign pixel_rgba_o = pix_q;
  assign in_bounds_o  = inb_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_pixel_inb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pixel_rgba_o != '0)) |-> in_bounds_o)
    else $error("pixel data returned for an off-buffer read");

endmodule

`default_nettype wire

// ----- hdl/abr_ram.sv -----
// ----------------------------------------------------------------------------
// abr_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/abr_mac.sv -----
// ----------------------------------------------------------------------------
// abr_mac
// Shared signed multiply-add unit: acc = op_a * op_b + addend, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module abr_mac import abr_pkg::*; (
  input  logic                    clk_i,
  input  mac_req_t                req_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [2*OP_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_q;

  assign prod = req_i.op_a * req_i.op_b;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= ACC_W'(prod) + req_i.addend;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire
